[sv/mips_subset_execute_core_macros.svh]
// Assertion macros shared by the checker of the execute core.
// Depends on nothing; the using scope provides clk and arst_n.
`ifndef MIPS_SUBSET_EXECUTE_CORE_MACROS_SVH
`define MIPS_SUBSET_EXECUTE_CORE_MACROS_SVH

// Property checked at every clock edge outside reset.
`define MSEC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define MSEC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/msec_pkg.sv]
// Shared types, constants and helper functions of the execute core.
// Used by every module of the block; depends on nothing.
package msec_pkg;

	// Storage sizes.
	localparam int MEM_WORDS  = 1024;
	localparam int PROG_DEPTH = 1024;
	localparam int MEM_AW     = $clog2(MEM_WORDS);
	localparam int NUM_REGS   = 32;

	// Field widths.
	localparam int PC_W    = 11;
	localparam int REG_W   = 5;
	localparam int DATA_W  = 32;
	localparam int LIMIT_W = 31;

	// Queue sizes (powers of two).
	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW    = $clog2(FQ_DEPTH);
	localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	// Configuration port.
	localparam int APB_AW  = 2;
	localparam int APB_DW  = 32;
	localparam logic [APB_AW-1:0] REG_ADDR_STACK_LIMIT = 2'd0;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd4194304;

	// Special registers.
	localparam logic [REG_W-1:0] REG_ZERO = 5'd0;
	localparam logic [REG_W-1:0] REG_AT   = 5'd1;
	localparam logic [REG_W-1:0] REG_K1   = 5'd27;
	localparam logic [REG_W-1:0] REG_SP   = 5'd29;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_SLT  = 4'd3,
		OP_ADDI = 4'd4,
		OP_LW   = 4'd5,
		OP_SW   = 4'd6,
		OP_BEQ  = 4'd7,
		OP_BNE  = 4'd8,
		OP_J    = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SP_BOUND = 2'd1,
		ST_RESERVED = 2'd2,
		ST_HALTED   = 2'd3
	} status_t;

	// One instruction word as it arrives.
	typedef struct packed {
		logic [3:0]         op;
		logic [REG_W-1:0]   dest_reg;
		logic [REG_W-1:0]   src_a;
		logic [REG_W-1:0]   src_b;
		logic signed [31:0] immediate;
		logic [9:0]         branch_target;
		logic [9:0]         mem_addr;
	} cmd_t;

	// One result word.
	typedef struct packed {
		logic [1:0]         status;
		logic [PC_W-1:0]    next_pc;
		logic               write_enable;
		logic [REG_W-1:0]   write_reg;
		logic signed [31:0] write_value;
		logic               branch_taken;
	} result_t;

	// Instruction word with its classification from the front end.
	typedef struct packed {
		cmd_t cmd;
		logic writes;
		logic rsv_dest;
		logic sp_dest;
	} entry_t;

	// Head of the instruction queue as seen by the back end.
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} head_t;

	// Next instruction index, saturating at the end of the program.
	function automatic logic [PC_W-1:0] pc_advance(input logic [PC_W-1:0] base);
		logic [PC_W:0] n;
		n = {1'b0, base} + (PC_W+1)'(1);
		if (n > (PC_W+1)'(PROG_DEPTH)) begin
			n = (PC_W+1)'(PROG_DEPTH);
		end
		return n[PC_W-1:0];
	endfunction

endpackage

[sv/msec_front.sv]
// Front end: accepts instruction words, classifies them and queues them.
// Depends on msec_pkg.
module msec_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  msec_pkg::cmd_t  cmd_word,
	input  logic            clearing,
	input  logic            deq,
	output msec_pkg::head_t head
);
	import msec_pkg::*;

	entry_t           fifo_q [FQ_DEPTH];
	logic [FQ_AW-1:0] wr_ptr_q;
	logic [FQ_AW-1:0] rd_ptr_q;
	logic [FQ_CW-1:0] count_q;
	entry_t           entry_d;
	logic             accept;

	// The queue refuses words while full or while data memory is being cleared.
	assign full   = (count_q == FQ_CW'(FQ_DEPTH)) || clearing;
	assign accept = push && !full;

	// Classify the word: does it write a register, and is its destination special.
	always_comb begin
		entry_d.cmd      = cmd_word;
		entry_d.writes   = cmd_word.op inside {OP_ADD, OP_SUB, OP_MUL, OP_SLT, OP_ADDI, OP_LW};
		entry_d.rsv_dest = cmd_word.dest_reg inside {REG_ZERO, REG_AT, REG_K1};
		entry_d.sp_dest  = (cmd_word.dest_reg == REG_SP);
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (accept) begin
			fifo_q[wr_ptr_q] <= entry_d;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + FQ_AW'(1);
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + FQ_AW'(1);
			end
			if (accept && !deq) begin
				count_q <= count_q + FQ_CW'(1);
			end else if (!accept && deq) begin
				count_q <= count_q - FQ_CW'(1);
			end
		end
	end

	assign head.valid = (count_q != '0);
	assign head.entry = fifo_q[rd_ptr_q];

endmodule

[sv/msec_back.sv]
// Back end: reads operands, executes one instruction per cycle unless stalled, and updates state.
// Holds the register file, data memory, program counter and halt flag; uses msec_pkg.
module msec_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  msec_pkg::head_t                   head,
	output logic                              deq,
	output logic                              clearing,
	input  logic [msec_pkg::OQ_CW-1:0]        out_count,
	input  logic [msec_pkg::LIMIT_W-1:0]      stack_limit,
	output logic                              res_push,
	output msec_pkg::result_t                 res_word
);
	import msec_pkg::*;

	// Storage.
	logic [DATA_W-1:0]   rf_mem [NUM_REGS];
	logic [NUM_REGS-1:0] rf_valid_q;
	logic [DATA_W-1:0]   dm_mem [MEM_WORDS];

	// Clearing pass over data memory after reset.
	logic              clear_q;
	logic [MEM_AW-1:0] clear_cnt_q;

	// Architectural state.
	logic [PC_W-1:0] pc_q;
	logic            halted_q;

	// Read stage registers.
	logic              valid_s1;
	entry_t            entry_s1;
	logic [DATA_W-1:0] rf_rd_a_s1;
	logic [DATA_W-1:0] rf_rd_b_s1;
	logic              vld_a_s1;
	logic              vld_b_s1;
	logic              byp_a_s1;
	logic              byp_b_s1;
	logic [DATA_W-1:0] rf_byp_s1;
	logic [DATA_W-1:0] dm_rd_s1;
	logic              byp_m_s1;
	logic [DATA_W-1:0] dm_byp_s1;

	// Execute signals.
	logic              issue;
	logic [MEM_AW-1:0] head_idx;
	logic [MEM_AW-1:0] exec_idx;
	logic [DATA_W-1:0] va;
	logic [DATA_W-1:0] vb;
	logic [DATA_W-1:0] ld;
	logic [DATA_W-1:0] prod;
	logic [DATA_W-1:0] value;
	logic              lt;
	logic              taken;
	logic [PC_W-1:0]   npc;
	logic [1:0]        status;
	logic              rf_we;
	logic              dm_we;
	logic              halted_d;
	logic              dm_wen;
	logic [MEM_AW-1:0] dm_waddr;
	logic [DATA_W-1:0] dm_wdata;

	// Issue when the result queue is sure to have room for everything in flight.
	assign issue = head.valid && !clear_q &&
		((OQ_CW+1)'(out_count) + (OQ_CW+1)'(valid_s1) < (OQ_CW+1)'(OQ_DEPTH));
	assign deq      = issue;
	assign clearing = clear_q;

	assign head_idx = MEM_AW'(head.entry.cmd.mem_addr);
	assign exec_idx = MEM_AW'(entry_s1.cmd.mem_addr);

	// Register file: written by execute, read registered at issue.
	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[entry_s1.cmd.dest_reg] <= value;
		end
		if (issue) begin
			rf_rd_a_s1 <= rf_mem[head.entry.cmd.src_a];
			rf_rd_b_s1 <= rf_mem[head.entry.cmd.src_b];
		end
	end

	// Data memory: one write port shared by clearing and stores, one registered read.
	assign dm_wen   = clear_q || dm_we;
	assign dm_waddr = clear_q ? clear_cnt_q : exec_idx;
	assign dm_wdata = clear_q ? '0 : va;

	always_ff @(posedge clk) begin
		if (dm_wen) begin
			dm_mem[dm_waddr] <= dm_wdata;
		end
		if (issue) begin
			dm_rd_s1 <= dm_mem[head_idx];
		end
	end

	// Read stage payload, with bypass marks for a write landing at the same edge.
	always_ff @(posedge clk) begin
		if (issue) begin
			entry_s1  <= head.entry;
			vld_a_s1  <= rf_valid_q[head.entry.cmd.src_a];
			vld_b_s1  <= rf_valid_q[head.entry.cmd.src_b];
			byp_a_s1  <= rf_we && (entry_s1.cmd.dest_reg == head.entry.cmd.src_a);
			byp_b_s1  <= rf_we && (entry_s1.cmd.dest_reg == head.entry.cmd.src_b);
			rf_byp_s1 <= value;
			byp_m_s1  <= dm_we && (exec_idx == head_idx);
			dm_byp_s1 <= va;
		end
	end

	// Operand selection: bypassed value, stored value, or zero if never written.
	always_comb begin
		va = byp_a_s1 ? rf_byp_s1 : (vld_a_s1 ? rf_rd_a_s1 : '0);
		vb = byp_b_s1 ? rf_byp_s1 : (vld_b_s1 ? rf_rd_b_s1 : '0);
		ld = byp_m_s1 ? dm_byp_s1 : dm_rd_s1;
	end

	assign prod = va * vb;
	assign lt   = ($signed(va) < $signed(vb));

	// Execute one instruction.
	always_comb begin
		value    = '0;
		taken    = 1'b0;
		npc      = pc_q;
		status   = ST_OK;
		rf_we    = 1'b0;
		dm_we    = 1'b0;
		halted_d = halted_q;
		if (valid_s1) begin
			if (halted_q) begin
				status = ST_HALTED;
			end else begin
				npc = pc_advance(pc_q);
				case (entry_s1.cmd.op)
					OP_ADD:  value = va + vb;
					OP_SUB:  value = va - vb;
					OP_MUL:  value = prod;
					OP_SLT:  value = {{(DATA_W-1){1'b0}}, lt};
					OP_ADDI: value = va + DATA_W'(unsigned'(entry_s1.cmd.immediate));
					OP_LW:   value = ld;
					OP_SW:   dm_we = 1'b1;
					OP_BEQ: begin
						if (va == vb) begin
							taken = 1'b1;
							npc   = pc_advance(PC_W'(entry_s1.cmd.branch_target));
						end
					end
					OP_BNE: begin
						if (va != vb) begin
							taken = 1'b1;
							npc   = pc_advance(PC_W'(entry_s1.cmd.branch_target));
						end
					end
					OP_J: begin
						taken = 1'b1;
						npc   = pc_advance(PC_W'(entry_s1.cmd.branch_target));
					end
					default: ;
				endcase
				// Destination checks for register-writing instructions.
				if (entry_s1.writes) begin
					if (entry_s1.rsv_dest) begin
						status = ST_RESERVED;
					end else if (entry_s1.sp_dest &&
						(value[DATA_W-1] || (value[LIMIT_W-1:0] > stack_limit))) begin
						status = ST_SP_BOUND;
					end else begin
						rf_we = 1'b1;
					end
					if (status != ST_OK) begin
						halted_d = 1'b1;
						npc      = pc_q;
					end
				end
			end
		end
	end

	// Result word.
	always_comb begin
		res_word              = '0;
		res_word.status       = status;
		res_word.next_pc      = npc;
		res_word.write_enable = rf_we;
		res_word.write_reg    = rf_we ? entry_s1.cmd.dest_reg : '0;
		res_word.write_value  = rf_we ? value : '0;
		res_word.branch_taken = taken;
	end
	assign res_push = valid_s1;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			pc_q        <= '0;
			halted_q    <= 1'b0;
			rf_valid_q  <= '0;
			clear_q     <= 1'b1;
			clear_cnt_q <= '0;
		end else begin
			valid_s1 <= issue;
			if (valid_s1) begin
				pc_q     <= npc;
				halted_q <= halted_d;
			end
			if (rf_we) begin
				rf_valid_q[entry_s1.cmd.dest_reg] <= 1'b1;
			end
			if (clear_q) begin
				clear_cnt_q <= clear_cnt_q + MEM_AW'(1);
				if (clear_cnt_q == MEM_AW'(MEM_WORDS - 1)) begin
					clear_q <= 1'b0;
				end
			end
		end
	end

endmodule

[sv/msec_out_queue.sv]
// Result queue: holds finished result words until the consumer pops them.
// Depends on msec_pkg.
module msec_out_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       res_push,
	input  msec_pkg::result_t          res_word,
	input  logic                       pop,
	output logic                       empty,
	output msec_pkg::result_t          result_word,
	output logic [msec_pkg::OQ_CW-1:0] count
);
	import msec_pkg::*;

	result_t          q_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q;
	logic [OQ_AW-1:0] rd_ptr_q;
	logic [OQ_CW-1:0] count_q;
	logic             take;

	assign empty       = (count_q == '0);
	assign take        = pop && !empty;
	assign result_word = q_q[rd_ptr_q];
	assign count       = count_q;

	// Storage; the back end never pushes into a full queue.
	always_ff @(posedge clk) begin
		if (res_push) begin
			q_q[wr_ptr_q] <= res_word;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= wr_ptr_q + OQ_AW'(1);
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + OQ_AW'(1);
			end
			if (res_push && !take) begin
				count_q <= count_q + OQ_CW'(1);
			end else if (!res_push && take) begin
				count_q <= count_q - OQ_CW'(1);
			end
		end
	end

endmodule

[sv/mips_subset_execute_core.sv]
// Execute core for a ten-instruction integer subset. One instruction word is taken per
// cycle while full is low, and one result word comes out per instruction, in order.
// A word leaves the instruction queue at the edge that loads the register file and data
// memory read ports. It then moves to the execute stage, which works on those registered
// operands with bypass of the write landing at the same edge, and enters the result
// queue at the next edge. Sustained rate is one instruction per cycle while the consumer
// keeps popping, set by the single execute stage and the four-entry result queue. After
// reset the data memory is cleared one word per cycle, so full stays high until the
// clearing pass ends; the stack limit register can be written meanwhile.
// Depends on msec_pkg, msec_front, msec_back and msec_out_queue.
module mips_subset_execute_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  msec_pkg::cmd_t              cmd_word,
	output logic                        empty,
	input  logic                        pop,
	output msec_pkg::result_t           result_word,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [msec_pkg::APB_AW-1:0] paddr,
	input  logic [msec_pkg::APB_DW-1:0] pwdata,
	output logic [msec_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import msec_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	head_t              head;
	logic               deq;
	logic               clearing;
	logic [OQ_CW-1:0]   out_count;
	logic               res_push;
	result_t            res_word;

	// Configuration register.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready &&
			(paddr == REG_ADDR_STACK_LIMIT)) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_ADDR_STACK_LIMIT) begin
			prdata = APB_DW'(limit_q);
		end
	end

	// Instruction queue.
	msec_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.cmd_word (cmd_word),
		.clearing (clearing),
		.deq      (deq),
		.head     (head)
	);

	// Operand read and execute.
	msec_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.deq         (deq),
		.clearing    (clearing),
		.out_count   (out_count),
		.stack_limit (limit_q),
		.res_push    (res_push),
		.res_word    (res_word)
	);

	// Result queue.
	msec_out_queue u_out_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_push    (res_push),
		.res_word    (res_word),
		.pop         (pop),
		.empty       (empty),
		.result_word (result_word),
		.count       (out_count)
	);

endmodule

[sv/msec_checker.sv]
// Port-level checker for the execute core, attached to the top level by bind.
// Depends on msec_pkg and mips_subset_execute_core_macros.svh.
`include "mips_subset_execute_core_macros.svh"

module msec_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              empty,
	input logic              pop,
	input msec_pkg::result_t result_word
);
	import msec_pkg::*;

	logic seen_err_q;

	// Remember that an error result word has been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_err_q <= 1'b0;
		end else if (pop && !empty &&
			((result_word.status == ST_SP_BOUND) || (result_word.status == ST_RESERVED))) begin
			seen_err_q <= 1'b1;
		end
	end

	// Once an error has come out, every later word reports the halt.
	`MSEC_ASSERT(a_halt_sticky, (pop && !empty && seen_err_q |-> result_word.status == ST_HALTED), "word after an error does not report halt")

	// A word that is not ok neither writes a register nor redirects the counter.
	`MSEC_ASSERT(a_err_no_effect, (!empty && (result_word.status != ST_OK) |-> !result_word.write_enable && !result_word.branch_taken), "failed word shows a write or a branch")

	// Without a register write the write fields read as zero.
	`MSEC_ASSERT(a_no_write_zero, (!empty && !result_word.write_enable |-> (result_word.write_reg == '0) && (result_word.write_value == '0)), "write fields set without a write")

	// A waiting word holds until it is popped.
	`MSEC_ASSERT(a_hold_stalled, (!empty && !pop |=> !empty && $stable(result_word)), "stalled result word changed")

	// A cycle spent in reset leaves no result word to pop at the following edge.
	`MSEC_ASSERT_ALWAYS(a_empty_in_reset, (!arst_n |=> empty), "result offered after reset")

endmodule

bind mips_subset_execute_core msec_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.result_word (result_word)
);

[tb/mips_subset_execute_core_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the execute core: directed and random instruction words are
// checked word by word against a behavioral model kept inside this file.
// Depends on msec_pkg and mips_subset_execute_core.
module mips_subset_execute_core_test;
	import msec_pkg::*;

	// Two copies of the core state: one steers the generator, one follows the core.
	localparam int PLAN = 0;
	localparam int LIVE = 1;
	localparam logic [3:0] OP_SPARE_LO = 4'd10;
	localparam logic [3:0] OP_SPARE_HI = 4'd15;
	localparam int IDLE_PCT     = 36;
	localparam int PHASE_WORDS  = 370;
	localparam int DRAIN_CYCLES = 10;
	localparam int REPORT_MAX   = 10;

	typedef enum int {
		HALT_ZERO,
		HALT_AT,
		HALT_K1,
		HALT_SP_NEG,
		HALT_SP_HIGH
	} halt_cause_t;

	logic              clk;
	logic              arst_n   = 1'b0;
	logic              push     = 1'b0;
	logic              full;
	cmd_t              cmd_word = '0;
	logic              empty;
	logic              pop      = 1'b0;
	result_t           result_word;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [APB_AW-1:0] paddr    = '0;
	logic [APB_DW-1:0] pwdata   = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	logic [DATA_W-1:0]  gpr [2][NUM_REGS];
	logic [DATA_W-1:0]  dmem [2][MEM_WORDS];
	logic [PC_W-1:0]    cur_pc [2];
	logic               stopped [2];
	logic [LIMIT_W-1:0] sp_limit [2];

	cmd_t    pending_words[$];
	result_t expected_results[$];
	logic    cmd_took;
	bit      steady    = 1'b0;
	int      err_count = 0;

	mips_subset_execute_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cmd_word(cmd_word),
		.empty(empty),
		.pop(pop),
		.result_word(result_word),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Next instruction index, held at the end of the program.
	function automatic logic [PC_W-1:0] step_pc(input logic [PC_W-1:0] base);
		if (base >= PC_W'(PROG_DEPTH)) begin
			return PC_W'(PROG_DEPTH);
		end
		return base + 1'b1;
	endfunction

	function automatic bit writes_reg(input logic [3:0] op);
		case (op)
			OP_ADD, OP_SUB, OP_MUL, OP_SLT, OP_ADDI, OP_LW: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit reserved_reg(input logic [REG_W-1:0] r);
		return r == REG_ZERO || r == REG_AT || r == REG_K1;
	endfunction

	function automatic bit sp_ok(input int w, input logic [DATA_W-1:0] v);
		return !v[DATA_W-1] && (v[LIMIT_W-1:0] <= sp_limit[w]);
	endfunction

	// Value that a register-writing instruction would write.
	function automatic logic [DATA_W-1:0] write_value_of(input int w, input cmd_t c);
		logic [DATA_W-1:0] va;
		logic [DATA_W-1:0] vb;
		va = gpr[w][c.src_a];
		vb = gpr[w][c.src_b];
		case (c.op)
			OP_ADD:  return va + vb;
			OP_SUB:  return va - vb;
			OP_MUL:  return va * vb;
			OP_SLT:  return ($signed(va) < $signed(vb)) ? 32'd1 : 32'd0;
			OP_ADDI: return va + c.immediate;
			OP_LW:   return dmem[w][c.mem_addr];
			default: return '0;
		endcase
	endfunction

	// Executes one instruction word on one copy of the state and returns its result word.
	function automatic result_t execute_word(input int w, input cmd_t c);
		result_t           r;
		logic [DATA_W-1:0] v;
		logic [PC_W-1:0]   npc;
		r = '0;
		if (stopped[w]) begin
			r.status  = ST_HALTED;
			r.next_pc = cur_pc[w];
			return r;
		end
		npc = step_pc(cur_pc[w]);
		case (c.op)
			OP_SW: begin
				dmem[w][c.mem_addr] = gpr[w][c.src_a];
			end
			OP_BEQ: begin
				if (gpr[w][c.src_a] == gpr[w][c.src_b]) begin
					r.branch_taken = 1'b1;
					npc = step_pc(PC_W'(c.branch_target));
				end
			end
			OP_BNE: begin
				if (gpr[w][c.src_a] != gpr[w][c.src_b]) begin
					r.branch_taken = 1'b1;
					npc = step_pc(PC_W'(c.branch_target));
				end
			end
			OP_J: begin
				r.branch_taken = 1'b1;
				npc = step_pc(PC_W'(c.branch_target));
			end
			default: ;
		endcase
		if (writes_reg(c.op)) begin
			v = write_value_of(w, c);
			if (reserved_reg(c.dest_reg)) begin
				r.status = ST_RESERVED;
			end else if (c.dest_reg == REG_SP && !sp_ok(w, v)) begin
				r.status = ST_SP_BOUND;
			end else begin
				gpr[w][c.dest_reg] = v;
				r.write_enable = 1'b1;
				r.write_reg    = c.dest_reg;
				r.write_value  = v;
			end
			// An error holds the counter and stops the core for good.
			if (r.status != ST_OK) begin
				stopped[w] = 1'b1;
				npc = cur_pc[w];
			end
		end
		cur_pc[w] = npc;
		r.next_pc = npc;
		return r;
	endfunction

	function automatic cmd_t word_of(input logic [3:0] op, input logic [REG_W-1:0] rd,
			input logic [REG_W-1:0] ra, input logic [REG_W-1:0] rb,
			input logic [31:0] imm, input logic [9:0] tgt, input logic [9:0] addr);
		cmd_t c;
		c.op            = op;
		c.dest_reg      = rd;
		c.src_a         = ra;
		c.src_b         = rb;
		c.immediate     = imm;
		c.branch_target = tgt;
		c.mem_addr      = addr;
		return c;
	endfunction

	// Queues a word for the driver. With tame set, a write that would halt the core is
	// moved to an ordinary register, so the run stays out of the halted state.
	function automatic void enqueue(input cmd_t c, input bit tame);
		logic [DATA_W-1:0] v;
		if (tame && writes_reg(c.op)) begin
			while (reserved_reg(c.dest_reg)) begin
				c.dest_reg = REG_W'($urandom_range(31, 2));
			end
			v = write_value_of(PLAN, c);
			if (c.dest_reg == REG_SP && !sp_ok(PLAN, v)) begin
				c.dest_reg = REG_W'($urandom_range(26, 2));
			end
		end
		void'(execute_word(PLAN, c));
		pending_words = {pending_words, c};
	endfunction

	function automatic cmd_t random_word();
		cmd_t c;
		int   pick;
		pick = $urandom_range(99, 0);
		if (pick < 5) begin
			c.op = 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
		end else begin
			c.op = 4'($urandom_range(OP_J, OP_ADD));
		end
		c.dest_reg = REG_W'($urandom_range(31, 0));
		c.src_a    = REG_W'($urandom_range(31, 0));
		// Equal compare registers make branches on equality come up often.
		if ($urandom_range(3, 0) == 0) begin
			c.src_b = c.src_a;
		end else begin
			c.src_b = REG_W'($urandom_range(31, 0));
		end
		case ($urandom_range(3, 0))
			0, 1: c.immediate = $urandom;
			2: c.immediate = 32'($urandom_range(32, 0)) - 32'd16;
			default: begin
				case ($urandom_range(3, 0))
					0: c.immediate = 32'h7FFF_FFFF;
					1: c.immediate = 32'h8000_0000;
					2: c.immediate = 32'hFFFF_FFFF;
					default: c.immediate = '0;
				endcase
			end
		endcase
		c.branch_target = 10'($urandom_range(1023, 0));
		if ($urandom_range(9, 0) == 0) begin
			c.branch_target = 10'h3FF;
		end
		// A few addresses are shared so that loads see earlier stores.
		if ($urandom_range(1, 0) == 0) begin
			c.mem_addr = 10'($urandom_range(7, 0));
		end else begin
			c.mem_addr = 10'($urandom_range(1023, 0));
		end
		// Legal stack pointer writes, the limit itself among them.
		if (pick >= 92) begin
			c.op       = OP_ADDI;
			c.dest_reg = REG_SP;
			c.src_a    = REG_ZERO;
			if ($urandom_range(1, 0) == 0) begin
				c.immediate = {1'b0, sp_limit[PLAN]};
			end else begin
				c.immediate = $urandom_range(sp_limit[PLAN], 0);
			end
		end
		return c;
	endfunction

	task automatic write_stack_limit(input logic [APB_DW-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_ADDR_STACK_LIMIT;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sp_limit[PLAN] = value[LIMIT_W-1:0];
		sp_limit[LIVE] = value[LIMIT_W-1:0];
	endtask

	// Returns at a rising edge once nothing is queued, offered or outstanding.
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_words.size() != 0 || push || expected_results.size() != 0);
	endtask

	// Driver: offers the next queued word and, unless steady, idles or stalls the result side at random.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!push || cmd_took) begin
				if (pending_words.size() != 0 &&
						(steady || $urandom_range(99, 0) >= IDLE_PCT)) begin
					cmd_word <= pending_words.pop_front();
					push     <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
			pop <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
		end
	end

	// Monitor: checks every popped word and predicts every word the core takes.
	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			cmd_took <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					err_count++;
					if (err_count <= REPORT_MAX) begin
						$display("unexpected result word %h", result_word);
					end
				end else begin
					want = expected_results.pop_front();
					if (result_word.status !== want.status ||
							result_word.next_pc !== want.next_pc ||
							result_word.write_enable !== want.write_enable ||
							result_word.write_reg !== want.write_reg ||
							result_word.write_value !== want.write_value ||
							result_word.branch_taken !== want.branch_taken) begin
						err_count++;
						if (err_count <= REPORT_MAX) begin
							$display("mismatch: expected st %0d pc %0d we %0b reg %0d val %h br %0b",
								want.status, want.next_pc, want.write_enable,
								want.write_reg, want.write_value, want.branch_taken);
							$display("          got      st %0d pc %0d we %0b reg %0d val %h br %0b",
								result_word.status, result_word.next_pc,
								result_word.write_enable, result_word.write_reg,
								result_word.write_value, result_word.branch_taken);
						end
					end
				end
			end
			cmd_took <= push && !full;
			if (push && !full) begin
				expected_results = {expected_results, execute_word(LIVE, cmd_word)};
			end
		end
	end

	initial begin
		logic [APB_DW-1:0] cfg_values [5];
		halt_cause_t       cause;
		for (int w = 0; w < 2; w++) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				gpr[w][i] = '0;
			end
			for (int i = 0; i < MEM_WORDS; i++) begin
				dmem[w][i] = '0;
			end
			cur_pc[w]   = '0;
			stopped[w]  = 1'b0;
			sp_limit[w] = LIMIT_RESET;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The reset value again, with the unused top bit set, during the clearing pass.
		write_stack_limit({1'b1, LIMIT_RESET});
		@(posedge clk);

		// Directed words: wrapping arithmetic, every operation, counter end and label 0.
		enqueue(word_of(OP_ADD, 2, 0, 0, 32'd0, 10'd0, 10'd0), 1'b1);
		enqueue(word_of(OP_ADDI, 2, 0, 0, 32'h7FFF_FFFF, 10'd0, 10'd0), 1'b1);
		enqueue(word_of(OP_ADDI, 3, 0, 0, 32'h8000_0000, 10'd0, 10'd0), 1'b1);
		enqueue(word_of(OP_ADD, 4, 2, 2, 32'd0, 10'd0, 10'd0), 1'b1);
		enqueue(word_of(OP_SUB, 5, 3, 2, 32'd0, 10'd0, 10'd0), 1'b1);
		enqueue(word_of(OP_MUL, 6, 2, 3, 32'd0, 10'd0, 10'd0), 1'b1);
		enqueue(word_of(OP_SLT, 7, 3, 2, 32'd0, 10'd0, 10'd0), 1'b1);
		enqueue(word_of(OP_SLT, 8, 2, 3, 32'd0, 10'd0, 10'd0), 1'b1);
		enqueue(word_of(OP_ADDI, 31, 0, 0, 32'hFFFF_FFFF, 10'd0, 10'd0), 1'b1);
		enqueue(word_of(OP_MUL, 30, 31, 31, 32'd0, 10'd0, 10'd0), 1'b1);
		enqueue(word_of(OP_SW, 0, 31, 0, 32'd0, 10'd0, 10'h3FF), 1'b1);
		enqueue(word_of(OP_LW, 9, 0, 0, 32'd0, 10'd0, 10'h3FF), 1'b1);
		enqueue(word_of(OP_LW, 10, 0, 0, 32'd0, 10'd0, 10'd5), 1'b1);
		enqueue(word_of(OP_SW, 0, 2, 0, 32'd0, 10'd0, 10'd0), 1'b1);
		enqueue(word_of(OP_LW, 11, 0, 0, 32'd0, 10'd0, 10'd0), 1'b1);
		enqueue(word_of(OP_BEQ, 0, 0, 0, 32'd0, 10'h3FF, 10'd0), 1'b1);
		enqueue(word_of(OP_ADD, 12, 2, 3, 32'd0, 10'd0, 10'd0), 1'b1);
		enqueue(word_of(OP_BNE, 0, 2, 3, 32'd0, 10'd0, 10'd0), 1'b1);
		enqueue(word_of(OP_BEQ, 0, 2, 3, 32'd0, 10'h3FF, 10'd0), 1'b1);
		enqueue(word_of(OP_BNE, 0, 31, 31, 32'd0, 10'h3FF, 10'd0), 1'b1);
		enqueue(word_of(OP_J, 0, 0, 0, 32'd0, 10'd0, 10'd0), 1'b1);
		enqueue(word_of(OP_SPARE_LO, 31, 31, 31, 32'hFFFF_FFFF, 10'h3FF, 10'h3FF), 1'b1);
		enqueue(word_of(OP_SPARE_HI, 31, 31, 31, 32'hFFFF_FFFF, 10'h3FF, 10'h3FF), 1'b1);
		enqueue(word_of(OP_ADDI, REG_SP, REG_ZERO, 0, {1'b0, LIMIT_RESET}, 10'd0, 10'd0),
			1'b1);
		enqueue(word_of(OP_ADDI, REG_SP, REG_ZERO, 0, 32'd0, 10'd0, 10'd0), 1'b1);

		// Random phases, each under its own stack limit; one phase runs without idling.
		cfg_values[0] = 32'd0;
		cfg_values[1] = 32'h7FFF_FFFF;
		cfg_values[2] = $urandom;
		cfg_values[3] = 32'd1;
		cfg_values[4] = $urandom;
		for (int p = 0; p < 5; p++) begin
			wait_idle();
			steady = (p == 2);
			write_stack_limit(cfg_values[p]);
			@(posedge clk);
			repeat (PHASE_WORDS) enqueue(random_word(), 1'b1);
		end

		// Only one error can be seen per run, since the halt lasts until reset.
		wait_idle();
		steady = 1'b0;
		cause  = halt_cause_t'($urandom_range(HALT_SP_HIGH, HALT_ZERO));
		case (cause)
			HALT_ZERO: enqueue(word_of(OP_ADD, REG_ZERO, 2, 3, 32'd0, 10'd0, 10'd0), 1'b0);
			HALT_AT: enqueue(word_of(OP_ADDI, REG_AT, 0, 0, 32'd5, 10'd0, 10'd0), 1'b0);
			HALT_K1: enqueue(word_of(OP_LW, REG_K1, 0, 0, 32'd0, 10'd0, 10'd1), 1'b0);
			HALT_SP_NEG: enqueue(word_of(OP_ADDI, REG_SP, REG_ZERO, 0, 32'h8000_0000,
				10'd0, 10'd0), 1'b0);
			default: enqueue(word_of(OP_ADDI, REG_SP, REG_ZERO, 0,
				{1'b0, sp_limit[PLAN]} + 32'd1, 10'd0, 10'd0), 1'b0);
		endcase
		repeat (8) enqueue(random_word(), 1'b0);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && expected_results.size() == 0) begin
			$display("mips_subset_execute_core_test: clean");
		end else begin
			$display("mips_subset_execute_core_test: errors");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#5_000_000;
		$display("mips_subset_execute_core_test: errors");
		$finish;
	end

endmodule
